>>> rtl/cht_pkg.sv
package cht_pkg;

   localparam int CMD_BITS = 2;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_CIRCLE_CIRCLE = 2'd0,
      CMD_POINT_CIRCLE  = 2'd1,
      CMD_POINT_BOX     = 2'd2,
      CMD_CIRCLE_BOX    = 2'd3
   } cmd_type;

   // control travelling beside the geometry from the select stages
   typedef struct packed {
      logic valid;
      logic box_test;
      logic box_hit;
   } sel_ctl_type;

endpackage

>>> rtl/cht_select.sv
module cht_select
   import cht_pkg::*;
#(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  cmd_type                      command,
   input  logic signed [COORD_BITS-1:0] first_x,
   input  logic signed [COORD_BITS-1:0] first_y,
   input  logic        [COORD_BITS-2:0] first_radius,
   input  logic signed [COORD_BITS-1:0] second_x,
   input  logic signed [COORD_BITS-1:0] second_y,
   input  logic        [COORD_BITS-2:0] second_radius,
   input  logic signed [COORD_BITS-1:0] box_left,
   input  logic signed [COORD_BITS-1:0] box_top,
   input  logic        [COORD_BITS-2:0] box_width,
   input  logic        [COORD_BITS-2:0] box_height,
   output sel_ctl_type                  ctl,
   output logic signed [COORD_BITS:0]   ax,
   output logic signed [COORD_BITS:0]   ay,
   output logic signed [COORD_BITS:0]   bx,
   output logic signed [COORD_BITS:0]   by,
   output logic        [COORD_BITS-1:0] reach
);

   localparam int W = COORD_BITS + 1;

   // stage 1: capture, box far edges
   logic                         s1_valid_ff;
   cmd_type                      s1_cmd_ff;
   logic signed [W-1:0]          s1_fx_ff, s1_fy_ff, s1_sx_ff, s1_sy_ff;
   logic signed [W-1:0]          s1_left_ff, s1_top_ff, s1_right_ff, s1_bottom_ff;
   logic        [COORD_BITS-2:0] s1_fr_ff, s1_sr_ff;
   logic signed [W-1:0]          s1_right_in, s1_bottom_in;

   assign s1_right_in  = $signed({box_left[COORD_BITS-1], box_left})
                       + $signed({2'b00, box_width});
   assign s1_bottom_in = $signed({box_top[COORD_BITS-1], box_top})
                       + $signed({2'b00, box_height});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff    <= command;
         s1_fx_ff     <= {first_x[COORD_BITS-1], first_x};
         s1_fy_ff     <= {first_y[COORD_BITS-1], first_y};
         s1_sx_ff     <= {second_x[COORD_BITS-1], second_x};
         s1_sy_ff     <= {second_y[COORD_BITS-1], second_y};
         s1_left_ff   <= {box_left[COORD_BITS-1], box_left};
         s1_top_ff    <= {box_top[COORD_BITS-1], box_top};
         s1_right_ff  <= s1_right_in;
         s1_bottom_ff <= s1_bottom_in;
         s1_fr_ff     <= first_radius;
         s1_sr_ff     <= second_radius;
      end
   end

   // stage 2: nearest box point, point-in-box, operand select
   logic signed [W-1:0]          near_x, near_y;
   logic                         box_hit_in;
   sel_ctl_type                  ctl_in, ctl_ff;
   logic signed [W-1:0]          ax_in, ay_in, bx_in, by_in;
   logic signed [W-1:0]          ax_ff, ay_ff, bx_ff, by_ff;
   logic        [COORD_BITS-1:0] reach_in, reach_ff;

   always_comb begin
      if (s1_fx_ff < s1_left_ff) begin
         near_x = s1_left_ff;
      end else if (s1_fx_ff > s1_right_ff) begin
         near_x = s1_right_ff;
      end else begin
         near_x = s1_fx_ff;
      end
      if (s1_fy_ff < s1_top_ff) begin
         near_y = s1_top_ff;
      end else if (s1_fy_ff > s1_bottom_ff) begin
         near_y = s1_bottom_ff;
      end else begin
         near_y = s1_fy_ff;
      end
   end

   assign box_hit_in = (s1_sx_ff >= s1_left_ff) && (s1_sx_ff <= s1_right_ff)
                    && (s1_sy_ff >= s1_top_ff) && (s1_sy_ff <= s1_bottom_ff);

   always_comb begin
      ctl_in.valid    = s1_valid_ff;
      ctl_in.box_test = 1'b0;
      ctl_in.box_hit  = box_hit_in;
      ax_in           = s1_sx_ff;
      ay_in           = s1_sy_ff;
      bx_in           = s1_fx_ff;
      by_in           = s1_fy_ff;
      reach_in        = {1'b0, s1_fr_ff};
      case (s1_cmd_ff)
         CMD_CIRCLE_CIRCLE: begin
            reach_in = {1'b0, s1_fr_ff} + {1'b0, s1_sr_ff};
         end
         CMD_POINT_CIRCLE: begin
            reach_in = {1'b0, s1_fr_ff};
         end
         CMD_POINT_BOX: begin
            ctl_in.box_test = 1'b1;
         end
         CMD_CIRCLE_BOX: begin
            ax_in = near_x;
            ay_in = near_y;
         end
         default: begin
            ctl_in.box_test = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ax_ff    <= ax_in;
         ay_ff    <= ay_in;
         bx_ff    <= bx_in;
         by_ff    <= by_in;
         reach_ff <= reach_in;
      end
   end

   assign ctl   = ctl_ff;
   assign ax    = ax_ff;
   assign ay    = ay_ff;
   assign bx    = bx_ff;
   assign by    = by_ff;
   assign reach = reach_ff;

endmodule

>>> rtl/cht_dist.sv
module cht_dist
   import cht_pkg::*;
#(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  sel_ctl_type                  ctl,
   input  logic signed [COORD_BITS:0]   ax,
   input  logic signed [COORD_BITS:0]   ay,
   input  logic signed [COORD_BITS:0]   bx,
   input  logic signed [COORD_BITS:0]   by,
   input  logic        [COORD_BITS-1:0] reach,
   output logic                         out_valid,
   output logic                         hit
);

   localparam int DW = COORD_BITS + 1;
   localparam int SW = 2 * DW;
   localparam int RW = 2 * COORD_BITS;

   // stage 3: absolute differences
   logic signed [DW:0]         diff_x, diff_y, mag_x, mag_y;
   sel_ctl_type                ctl3_ff;
   logic [DW-1:0]              dx_ff, dy_ff;
   logic [COORD_BITS-1:0]      reach3_ff;

   assign diff_x = {ax[COORD_BITS], ax} - {bx[COORD_BITS], bx};
   assign diff_y = {ay[COORD_BITS], ay} - {by[COORD_BITS], by};
   assign mag_x  = diff_x[DW] ? -diff_x : diff_x;
   assign mag_y  = diff_y[DW] ? -diff_y : diff_y;

   // stage 4: squares
   sel_ctl_type ctl4_ff;
   logic [SW-1:0] sq_x_in, sq_y_in, sq_x_ff, sq_y_ff;
   logic [RW-1:0] r2_in, r2_ff;

   assign sq_x_in = dx_ff * dx_ff;
   assign sq_y_in = dy_ff * dy_ff;
   assign r2_in   = reach3_ff * reach3_ff;

   // stage 5: sum, compare, result word
   logic [SW:0] d2;
   logic        hit_in, hit_ff, valid5_ff;

   assign d2     = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
   assign hit_in = ctl4_ff.box_test ? ctl4_ff.box_hit : (d2 <= {3'b000, r2_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff.valid <= 1'b0;
         ctl4_ff.valid <= 1'b0;
         valid5_ff     <= 1'b0;
      end else if (advance) begin
         ctl3_ff       <= ctl;
         ctl4_ff       <= ctl3_ff;
         valid5_ff     <= ctl4_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff            <= mag_x[DW-1:0];
         dy_ff            <= mag_y[DW-1:0];
         reach3_ff        <= reach;
         sq_x_ff          <= sq_x_in;
         sq_y_ff          <= sq_y_in;
         r2_ff            <= r2_in;
         hit_ff           <= hit_in;
      end
   end

   assign out_valid = valid5_ff;
   assign hit       = hit_ff;

endmodule

>>> rtl/collision_hit_tester.sv
// channel  | valid / ready         | tdata                                  | tuser
// req_     | req_tvalid/req_tready | ten geometry fields, see port comment  | command
// rsp_     | rsp_tvalid/rsp_tready | hit in bit 0, zero above               | -
//
// five register stages: capture, box clamp, differences, squares, compare
// one word accepted per cycle while the result register is free or being taken
// reset clears the stage valid bits only
// a stall on rsp_tready holds every stage; req_tready is low only while the
// result register is full and not being taken
module collision_hit_tester
   import cht_pkg::*;
#(
   parameter int COORD_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // first_x, first_y, first_radius, second_x, second_y, second_radius,
   // box_left, box_top, box_width, box_height, zero pad
   input  logic [((6 * COORD_BITS + 4 * (COORD_BITS - 1) + 7) / 8) * 8 - 1:0] req_tdata,
   // command
   input  logic [CMD_BITS-1:0]     req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // hit, zero pad
   output logic [7:0]              rsp_tdata
);

   localparam int C         = COORD_BITS;
   localparam int R         = COORD_BITS - 1;
   localparam int O_FX      = 0;
   localparam int O_FY      = O_FX + C;
   localparam int O_FR      = O_FY + C;
   localparam int O_SX      = O_FR + R;
   localparam int O_SY      = O_SX + C;
   localparam int O_SR      = O_SY + C;
   localparam int O_BL      = O_SR + R;
   localparam int O_BT      = O_BL + C;
   localparam int O_BW      = O_BT + C;
   localparam int O_BH      = O_BW + R;

   logic                advance;
   sel_ctl_type         sel_ctl;
   logic signed [C:0]   ax, ay, bx, by;
   logic [C-1:0]        reach;
   logic                out_valid, hit;

   assign advance    = !out_valid || rsp_tready;
   assign req_tready = advance;

   cht_select #(
      .COORD_BITS(COORD_BITS)
   ) u_select (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (req_tvalid),
      .command       (cmd_type'(req_tuser)),
      .first_x       ($signed(req_tdata[O_FX +: C])),
      .first_y       ($signed(req_tdata[O_FY +: C])),
      .first_radius  (req_tdata[O_FR +: R]),
      .second_x      ($signed(req_tdata[O_SX +: C])),
      .second_y      ($signed(req_tdata[O_SY +: C])),
      .second_radius (req_tdata[O_SR +: R]),
      .box_left      ($signed(req_tdata[O_BL +: C])),
      .box_top       ($signed(req_tdata[O_BT +: C])),
      .box_width     (req_tdata[O_BW +: R]),
      .box_height    (req_tdata[O_BH +: R]),
      .ctl           (sel_ctl),
      .ax            (ax),
      .ay            (ay),
      .bx            (bx),
      .by            (by),
      .reach         (reach)
   );

   cht_dist #(
      .COORD_BITS(COORD_BITS)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctl       (sel_ctl),
      .ax        (ax),
      .ay        (ay),
      .bx        (bx),
      .by        (by),
      .reach     (reach),
      .out_valid (out_valid),
      .hit       (hit)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {7'b0000000, hit};

endmodule

>>> rtl/cht_checker.sv
module cht_checker
   import cht_pkg::*;
#(
   parameter int COORD_BITS = 24
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic [((6 * COORD_BITS + 4 * (COORD_BITS - 1) + 7) / 8) * 8 - 1:0] req_tdata,
   input logic [CMD_BITS-1:0]  req_tuser,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [7:0]           rsp_tdata
);

   // stalled result word stays put
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // input is refused only while a full result register is held
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready not tied to result register space");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'b0000000)
      else $error("rsp pad bits not zero");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind collision_hit_tester cht_checker #(.COORD_BITS(COORD_BITS)) u_cht_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import cht_pkg::*;

   localparam int COORD_BITS = 24;
   localparam int C = COORD_BITS;
   localparam int R = COORD_BITS - 1;
   localparam int DATA_BITS = ((6 * C + 4 * R) + 7) / 8 * 8;

   localparam int OFS_FX = 0;
   localparam int OFS_FY = OFS_FX + C;
   localparam int OFS_FR = OFS_FY + C;
   localparam int OFS_SX = OFS_FR + R;
   localparam int OFS_SY = OFS_SX + C;
   localparam int OFS_SR = OFS_SY + C;
   localparam int OFS_BL = OFS_SR + R;
   localparam int OFS_BT = OFS_BL + C;
   localparam int OFS_BW = OFS_BT + C;
   localparam int OFS_BH = OFS_BW + R;

   localparam longint COORD_MAX = (longint'(1) << (C - 1)) - 1;
   localparam longint COORD_MIN = -(longint'(1) << (C - 1));
   localparam longint RADIUS_MAX = (longint'(1) << R) - 1;

   localparam int PIPE_LATENCY = 5;
   localparam int RANDOM_WORDS = 550;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      cmd_type                cmd;
      logic signed [C-1:0]    first_x;
      logic signed [C-1:0]    first_y;
      logic        [R-1:0]    first_radius;
      logic signed [C-1:0]    second_x;
      logic signed [C-1:0]    second_y;
      logic        [R-1:0]    second_radius;
      logic signed [C-1:0]    box_left;
      logic signed [C-1:0]    box_top;
      logic        [R-1:0]    box_width;
      logic        [R-1:0]    box_height;
   } hit_query_type;

   class hit_scoreboard_type;
      bit pending_hits[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      function bit reaches(longint ax, longint ay, longint bx, longint by, longint reach);
         longint dx;
         longint dy;
         dx = ax - bx;
         dy = ay - by;
         return (dx * dx + dy * dy) <= (reach * reach);
      endfunction

      function void note_request(logic [CMD_BITS-1:0] user, logic [DATA_BITS-1:0] word);
         longint fx, fy, fr, sx, sy, sr;
         longint left, top, right, bottom, nx, ny;
         bit hit;
         fx = longint'($signed(word[OFS_FX +: C]));
         fy = longint'($signed(word[OFS_FY +: C]));
         fr = longint'(word[OFS_FR +: R]);
         sx = longint'($signed(word[OFS_SX +: C]));
         sy = longint'($signed(word[OFS_SY +: C]));
         sr = longint'(word[OFS_SR +: R]);
         left = longint'($signed(word[OFS_BL +: C]));
         top = longint'($signed(word[OFS_BT +: C]));
         right = left + longint'(word[OFS_BW +: R]);
         bottom = top + longint'(word[OFS_BH +: R]);
         case (cmd_type'(user))
            CMD_CIRCLE_CIRCLE: hit = reaches(fx, fy, sx, sy, fr + sr);
            CMD_POINT_CIRCLE:  hit = reaches(sx, sy, fx, fy, fr);
            CMD_POINT_BOX:     hit = (sx >= left) && (sx <= right) &&
                                     (sy >= top) && (sy <= bottom);
            default: begin
               nx = (fx < left) ? left : ((fx > right) ? right : fx);
               ny = (fy < top) ? top : ((fy > bottom) ? bottom : fy);
               hit = reaches(nx, ny, fx, fy, fr);
            end
         endcase
         pending_hits.push_back(hit);
      endfunction

      function void check_result(logic [7:0] word);
         bit wanted;
         if (pending_hits.size() == 0) begin
            $display("%0t: result word %0h with no hit pending", $time, word);
            errors++;
            return;
         end
         wanted = pending_hits.pop_front();
         if (word[0] !== wanted) begin
            $display("%0t: hit expected %0b actual %0b", $time, wanted, word[0]);
            errors++;
         end
         if (word[7:1] !== 7'd0) begin
            $display("%0t: pad expected 0 actual %0h", $time, word[7:1]);
            errors++;
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // first_x, first_y, first_radius, second_x, second_y, second_radius,
   // box_left, box_top, box_width, box_height, zero pad
   logic [DATA_BITS-1:0]    req_tdata = '0;
   // command
   logic [CMD_BITS-1:0]     req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // hit, zero pad
   logic [7:0]              rsp_tdata;

   hit_scoreboard_type sb;
   int burst_left = 0;
   int ready_run = 0;
   int quiet_cycles = 0;

   collision_hit_tester #(
      .COORD_BITS(COORD_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // receiver stall pattern: long open stretches, choppy toggling and longer holds
   always @(negedge clock) begin
      if (ready_run == 0) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               rsp_tready = 1'b1;
               ready_run = $urandom_range(30, 80);
            end
            2, 3, 4, 5: begin
               rsp_tready = ~rsp_tready;
               ready_run = $urandom_range(0, 3);
            end
            6, 7: begin
               rsp_tready = 1'b0;
               ready_run = $urandom_range(5, 20);
            end
            default: begin
               rsp_tready = 1'b1;
               ready_run = $urandom_range(1, 10);
            end
         endcase
      end else begin
         ready_run--;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic hit_query_type make_query(cmd_type cmd, longint fx, longint fy,
                                                longint fr, longint sx, longint sy,
                                                longint sr, longint bl, longint bt,
                                                longint bw, longint bh);
      hit_query_type q;
      q.cmd = cmd;
      q.first_x = C'(fx);
      q.first_y = C'(fy);
      q.first_radius = R'(fr);
      q.second_x = C'(sx);
      q.second_y = C'(sy);
      q.second_radius = R'(sr);
      q.box_left = C'(bl);
      q.box_top = C'(bt);
      q.box_width = R'(bw);
      q.box_height = R'(bh);
      return q;
   endfunction

   function automatic longint near(longint base, longint spread);
      return base + longint'($urandom_range(0, 32'(2 * spread))) - spread;
   endfunction

   function automatic hit_query_type random_query();
      hit_query_type q;
      int mode;
      longint span, cx, cy, fr, sr;
      mode = $urandom_range(0, 9);
      q.cmd = cmd_type'($urandom_range(0, 3));
      q.first_x = C'($urandom());
      q.first_y = C'($urandom());
      q.first_radius = R'($urandom());
      q.second_x = C'($urandom());
      q.second_y = C'($urandom());
      q.second_radius = R'($urandom());
      q.box_left = C'($urandom());
      q.box_top = C'($urandom());
      q.box_width = R'($urandom());
      q.box_height = R'($urandom());
      // shapes placed close together so hits and misses both happen
      if (mode >= 3) begin
         span = longint'(1) << $urandom_range(2, 20);
         cx = longint'(q.first_x) / 2;
         cy = longint'(q.first_y) / 2;
         fr = longint'($urandom_range(0, 32'(span)));
         sr = longint'($urandom_range(0, 32'(span)));
         q.first_x = C'(cx);
         q.first_y = C'(cy);
         q.first_radius = R'(fr);
         q.second_radius = R'(sr);
         q.second_x = C'(near(cx, 2 * span));
         q.second_y = C'(near(cy, 2 * span));
         q.box_left = C'(near(cx, 2 * span));
         q.box_top = C'(near(cy, 2 * span));
         q.box_width = R'($urandom_range(0, 32'(2 * span)));
         q.box_height = R'($urandom_range(0, 32'(2 * span)));
         // boundary cases: just touching, or one step either side
         if (mode == 9) begin
            case (q.cmd)
               CMD_CIRCLE_CIRCLE: begin
                  q.second_x = C'(cx + fr + sr + longint'($urandom_range(0, 2)) - 1);
                  q.second_y = C'(cy);
               end
               CMD_POINT_CIRCLE: begin
                  q.second_x = C'(cx);
                  q.second_y = C'(cy - fr - longint'($urandom_range(0, 2)) + 1);
               end
               CMD_POINT_BOX: begin
                  q.second_x = C'(longint'(q.box_left) + longint'(q.box_width) +
                                  longint'($urandom_range(0, 2)) - 1);
                  q.second_y = C'(longint'(q.box_top) +
                                  longint'($urandom_range(0, 2)) - 1);
               end
               default: begin
                  q.box_left = C'(cx + fr + longint'($urandom_range(0, 2)) - 1);
                  q.box_top = C'(cy - longint'($urandom_range(0, 32'(span))));
               end
            endcase
         end
      end
      return q;
   endfunction

   task automatic send_query(hit_query_type q);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = q.cmd;
      req_tdata = '0;
      req_tdata[OFS_FX +: C] = q.first_x;
      req_tdata[OFS_FY +: C] = q.first_y;
      req_tdata[OFS_FR +: R] = q.first_radius;
      req_tdata[OFS_SX +: C] = q.second_x;
      req_tdata[OFS_SY +: C] = q.second_y;
      req_tdata[OFS_SR +: R] = q.second_radius;
      req_tdata[OFS_BL +: C] = q.box_left;
      req_tdata[OFS_BT +: C] = q.box_top;
      req_tdata[OFS_BW +: R] = q.box_width;
      req_tdata[OFS_BH +: R] = q.box_height;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // circle against circle: touching, just apart, diagonal, extremes, zero radii
      send_query(make_query(CMD_CIRCLE_CIRCLE, 0, 0, 512, 1280, 0, 768, 0, 0, 0, 0));
      send_query(make_query(CMD_CIRCLE_CIRCLE, 0, 0, 512, 1281, 0, 768, 0, 0, 0, 0));
      send_query(make_query(CMD_CIRCLE_CIRCLE, 0, 0, 1000, 768, 1024, 280, 0, 0, 0, 0));
      send_query(make_query(CMD_CIRCLE_CIRCLE, 0, 0, 1000, 768, 1024, 279, 0, 0, 0, 0));
      send_query(make_query(CMD_CIRCLE_CIRCLE, COORD_MIN, COORD_MIN, RADIUS_MAX,
                            COORD_MAX, COORD_MAX, RADIUS_MAX, 0, 0, 0, 0));
      send_query(make_query(CMD_CIRCLE_CIRCLE, COORD_MIN, 0, RADIUS_MAX,
                            COORD_MAX - 1, 0, RADIUS_MAX, 0, 0, 0, 0));
      send_query(make_query(CMD_CIRCLE_CIRCLE, -7, 9, 0, -7, 9, 0, 0, 0, 0, 0));
      send_query(make_query(CMD_CIRCLE_CIRCLE, -7, 9, 0, -7, 10, 0, 0, 0, 0, 0));
      // point against circle
      send_query(make_query(CMD_POINT_CIRCLE, 100, -100, 5, 103, -96, 0, 0, 0, 0, 0));
      send_query(make_query(CMD_POINT_CIRCLE, 100, -100, 5, 103, -95, 0, 0, 0, 0, 0));
      send_query(make_query(CMD_POINT_CIRCLE, 100, -100, 0, 100, -100, 0, 0, 0, 0, 0));
      send_query(make_query(CMD_POINT_CIRCLE, COORD_MAX, COORD_MAX, RADIUS_MAX,
                            COORD_MIN, COORD_MIN, 0, 0, 0, 0, 0));
      // point against box: corners, one step outside, zero extent, extremes
      send_query(make_query(CMD_POINT_BOX, 0, 0, 0, 20, 20, 0, -10, -20, 30, 40));
      send_query(make_query(CMD_POINT_BOX, 0, 0, 0, 21, 20, 0, -10, -20, 30, 40));
      send_query(make_query(CMD_POINT_BOX, 0, 0, 0, -10, -20, 0, -10, -20, 30, 40));
      send_query(make_query(CMD_POINT_BOX, 0, 0, 0, -10, -21, 0, -10, -20, 30, 40));
      send_query(make_query(CMD_POINT_BOX, 0, 0, 0, 55, 66, 0, 55, 66, 0, 0));
      send_query(make_query(CMD_POINT_BOX, 0, 0, 0, COORD_MAX, COORD_MAX, 0,
                            COORD_MAX, COORD_MAX, RADIUS_MAX, RADIUS_MAX));
      send_query(make_query(CMD_POINT_BOX, 0, 0, 0, COORD_MIN, COORD_MAX, 0,
                            COORD_MIN, COORD_MIN, RADIUS_MAX, RADIUS_MAX));
      // circle against box: inside, corner touch and miss, edge touch, extremes
      send_query(make_query(CMD_CIRCLE_BOX, 50, 50, 0, 0, 0, 0, 0, 0, 100, 100));
      send_query(make_query(CMD_CIRCLE_BOX, 103, 104, 5, 0, 0, 0, 0, 0, 100, 100));
      send_query(make_query(CMD_CIRCLE_BOX, 103, 104, 4, 0, 0, 0, 0, 0, 100, 100));
      send_query(make_query(CMD_CIRCLE_BOX, -30, 40, 30, 0, 0, 0, 0, 0, 100, 100));
      send_query(make_query(CMD_CIRCLE_BOX, COORD_MAX, COORD_MIN, RADIUS_MAX, 0, 0, 0,
                            COORD_MIN, COORD_MAX, RADIUS_MAX, RADIUS_MAX));

      repeat (RANDOM_WORDS) send_query(random_query());
      @(negedge clock);
      req_tvalid = 1'b0;

      while (sb.pending_hits.size() != 0) @(posedge clock);
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
rtl/cht_pkg.sv
rtl/cht_select.sv
rtl/cht_dist.sv
rtl/collision_hit_tester.sv
rtl/cht_checker.sv
sim/tb.sv
